[sv/rars_pkg.sv]
// Shared types and constants for the range-add / range-sum store.
`default_nettype none

package rars_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int CFG_W = 11;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_SETU,
    OP_RD,
    OP_UWR,
    OP_SETQ,
    OP_QACC,
    OP_MLO,
    OP_MHI,
    OP_MFIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel;    // which range endpoint
  } dp_ctl_t;

  typedef struct packed {
    logic empty;
    logic is_sum;
    logic clr_last;
    logic upd_done;
    logic qry_done;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/rars_dp.sv]
// Datapath: two Fenwick tables, index walker, accumulators and split multiplier.
`default_nettype none

module rars_dp #(
  parameter int MAX_ELEMENTS = rars_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rars_pkg::dp_ctl_t          ctl,
  output rars_pkg::dp_sts_t               sts,
  input  wire logic                       cfg_we,
  input  wire logic [rars_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       in_cmd,
  input  wire logic [rars_pkg::IDX_W-1:0] in_first_index,
  input  wire logic [rars_pkg::IDX_W-1:0] in_last_index,
  input  wire logic signed [rars_pkg::VAL_W-1:0] in_add_value,
  output logic                            out_valid,
  output logic signed [rars_pkg::SUM_W-1:0] out_range_sum
);
  import rars_pkg::*;

  localparam int LW = $clog2(MAX_ELEMENTS + 1);
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int XW = ((LW > IDX_W) ? LW : IDX_W) + 1;
  localparam int CW = XW + 1;
  localparam int LEN_RST = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

  logic [SUM_W-1:0] mem1 [MAX_ELEMENTS];
  logic [SUM_W-1:0] mem2 [MAX_ELEMENTS];

  logic [LW-1:0]    len_r;
  logic [AW-1:0]    clr_idx_r;
  logic             is_sum_r;
  logic [XW-1:0]    a_r, bc_r, k_r;
  logic signed [VAL_W-1:0] v_r;
  logic [CW-1:0]    i_r;
  logic [SUM_W-1:0] rd1_r, rd2_r, d1_r, d2_r, s1_r, s2_r, prod_r, pre_r, res_r;
  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;

  logic [31:0]      cfg_ext;
  logic [LW-1:0]    cfg_len;
  logic [XW-1:0]    a_in, b_in, len_x, b_clamp, upos;
  logic signed [XW:0]       upos_s;
  logic signed [VAL_W+XW:0] umul;
  logic [SUM_W-1:0] umul_ext, v_ext;
  logic [CW-1:0]    lowbit;
  logic [AW-1:0]    addr;
  logic [VAL_W+XW-1:0] lo_mul, hi_mul;
  logic [SUM_W-1:0] fin_sum;

  assign cfg_ext = {{(32-CFG_W){1'b0}}, cfg_data};
  assign cfg_len = (cfg_data == '0) ? LW'(1) :
                   (cfg_ext > 32'(MAX_ELEMENTS)) ? LW'(MAX_ELEMENTS) : LW'(cfg_data);

  assign a_in    = XW'(in_first_index);
  assign b_in    = XW'(in_last_index);
  assign len_x   = XW'(len_r);
  assign b_clamp = (b_in >= len_x) ? len_x - XW'(1) : b_in;

  // Fenwick point updates: +v at a+1, -v at b+2; second table gets v*(pos-1)
  assign upos     = ctl.sel ? bc_r + XW'(1) : a_r;
  assign upos_s   = {1'b0, upos};
  assign umul     = v_r * upos_s;
  assign umul_ext = {{(SUM_W-VAL_W-XW-1){umul[VAL_W+XW]}}, umul};
  assign v_ext    = {{(SUM_W-VAL_W){v_r[VAL_W-1]}}, v_r};

  assign lowbit  = i_r & (~i_r + CW'(1));
  assign addr    = AW'(i_r - CW'(1));
  assign lo_mul  = k_r * s1_r[31:0];
  assign hi_mul  = k_r * s1_r[63:32];
  assign fin_sum = pre_r + prod_r;

  always_comb begin
    sts.empty    = (a_r >= len_x) || (a_r > bc_r);
    sts.is_sum   = is_sum_r;
    sts.clr_last = (clr_idx_r == AW'(MAX_ELEMENTS - 1));
    sts.upd_done = (i_r > CW'(len_r));
    sts.qry_done = (i_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LW'(LEN_RST);
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctl.op == OP_OUT);
      if (cfg_we) begin
        len_r     <= cfg_len;
        clr_idx_r <= '0;
      end else if (ctl.op == OP_CLR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_CLR: begin
        mem1[clr_idx_r] <= '0;
        mem2[clr_idx_r] <= '0;
      end
      OP_RD: begin
        rd1_r <= mem1[addr];
        rd2_r <= mem2[addr];
      end
      OP_UWR: begin
        mem1[addr] <= rd1_r + d1_r;
        mem2[addr] <= rd2_r + d2_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        is_sum_r <= in_cmd;
        a_r      <= a_in;
        bc_r     <= b_clamp;
        v_r      <= in_add_value;
        res_r    <= '0;
      end
      OP_SETU: begin
        i_r  <= CW'(upos) + CW'(1);
        d1_r <= ctl.sel ? -v_ext : v_ext;
        d2_r <= ctl.sel ? -umul_ext : umul_ext;
      end
      OP_UWR: i_r <= i_r + lowbit;
      OP_SETQ: begin
        i_r  <= ctl.sel ? CW'(a_r) : CW'(bc_r) + CW'(1);
        k_r  <= ctl.sel ? a_r : bc_r + XW'(1);
        s1_r <= '0;
        s2_r <= '0;
      end
      OP_QACC: begin
        s1_r <= s1_r + rd1_r;
        s2_r <= s2_r + rd2_r;
        i_r  <= i_r - lowbit;
      end
      OP_MLO: prod_r <= SUM_W'(lo_mul);
      OP_MHI: begin
        pre_r  <= prod_r - s2_r;
        prod_r <= {hi_mul[31:0], 32'd0};
      end
      OP_MFIN: res_r <= ctl.sel ? res_r - fin_sum : fin_sum;
      OP_OUT: out_sum_r <= res_r;
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

endmodule

`default_nettype wire

[sv/rars_ctrl.sv]
// Controller: sequences clearing, Fenwick walks and the product steps.
`default_nettype none

module rars_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              cfg_we,
  input  wire rars_pkg::dp_sts_t sts,
  output rars_pkg::dp_ctl_t      ctl,
  output logic                   busy
);
  import rars_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHK, ST_USET, ST_URD, ST_UWR,
    ST_QSET, ST_QRD, ST_QACC, ST_MLO, ST_MHI, ST_MFIN, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ctl.op    = OP_NONE;
    ctl.sel   = phase_r;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.op = OP_CLR;
        if (!cfg_we && sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_we) begin
          state_nxt = ST_CLEAR;
        end else if (start) begin
          ctl.op    = OP_LOAD;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        phase_nxt = 1'b0;
        if (sts.empty) state_nxt = sts.is_sum ? ST_OUT : ST_IDLE;
        else           state_nxt = sts.is_sum ? ST_QSET : ST_USET;
      end
      ST_USET: begin
        ctl.op    = OP_SETU;
        state_nxt = ST_URD;
      end
      ST_URD: begin
        if (sts.upd_done) begin
          phase_nxt = 1'b1;
          state_nxt = phase_r ? ST_IDLE : ST_USET;
        end else begin
          ctl.op    = OP_RD;
          state_nxt = ST_UWR;
        end
      end
      ST_UWR: begin
        ctl.op    = OP_UWR;
        state_nxt = ST_URD;
      end
      ST_QSET: begin
        ctl.op    = OP_SETQ;
        state_nxt = ST_QRD;
      end
      ST_QRD: begin
        if (sts.qry_done) begin
          state_nxt = ST_MLO;
        end else begin
          ctl.op    = OP_RD;
          state_nxt = ST_QACC;
        end
      end
      ST_QACC: begin
        ctl.op    = OP_QACC;
        state_nxt = ST_QRD;
      end
      ST_MLO: begin
        ctl.op    = OP_MLO;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        ctl.op    = OP_MHI;
        state_nxt = ST_MFIN;
      end
      ST_MFIN: begin
        ctl.op    = OP_MFIN;
        phase_nxt = 1'b1;
        state_nxt = phase_r ? ST_OUT : ST_QSET;
      end
      ST_OUT: begin
        ctl.op    = OP_OUT;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

[sv/range_add_range_sum_tree.sv]
// Top level of the range-add / range-sum store.
//
// Commands: pulse start with busy low; in_cmd 0 adds in_add_value to every
// element from in_first_index to in_last_index, in_cmd 1 requests the sum.
// A sum returns one beat on out_range_sum marked by a one-cycle out_valid;
// an add returns nothing. The receiver cannot stall the output.
// Storage is a pair of Fenwick tables (one memory each, one read-modify-write
// per node), so a command walks about log2(length) nodes per endpoint.
// Add: load, check, then per endpoint a set-up step and a read/write pair
// per node, closed by a read state that finds the walk done.
// Sum: load, check, then per prefix a set-up step, a read/accumulate pair
// per node and the 3-step split multiply; an output step registers the beat.
// Empty ranges skip the walks: add returns to idle, sum outputs zero.
// Reset, or a cfg_we/cfg_data write when idle or clearing, starts a clearing
// pass over all MAX_ELEMENTS entries, one entry per cycle, with busy high.
// The length register resets to 1024 (or MAX_ELEMENTS if smaller).
`default_nettype none

module range_add_range_sum_tree #(
  parameter int MAX_ELEMENTS = rars_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_cmd,
  input  wire logic [rars_pkg::IDX_W-1:0]        in_first_index,
  input  wire logic [rars_pkg::IDX_W-1:0]        in_last_index,
  input  wire logic signed [rars_pkg::VAL_W-1:0] in_add_value,
  output logic                                   out_valid,
  output logic signed [rars_pkg::SUM_W-1:0]      out_range_sum,
  input  wire logic                              cfg_we,
  input  wire logic [rars_pkg::CFG_W-1:0]        cfg_data
);
  import rars_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  rars_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_we (cfg_we),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  rars_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_cmd         (in_cmd),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_add_value   (in_add_value),
    .out_valid      (out_valid),
    .out_range_sum  (out_range_sum)
  );

endmodule

`default_nettype wire
